>>> hdl/ssce_pkg.sv
// Shared types and constants for the serial slave command engine.
// Used by every module under hdl; no dependencies of its own.
package ssce_pkg;

   // bus event codes
   localparam logic [2:0] OP_WRITE_BYTE = 3'd0;
   localparam logic [2:0] OP_READ_BYTE  = 3'd1;
   localparam logic [2:0] OP_WRITE_END  = 3'd2;
   localparam logic [2:0] OP_READ_NACK  = 3'd3;
   localparam logic [2:0] OP_HALF_TICK  = 3'd4;
   localparam logic [2:0] OP_SEC_TICK   = 3'd5;

   // command bytes
   localparam logic [7:0] CMD_ADD     = 8'h61;
   localparam logic [7:0] CMD_SUB     = 8'h64;
   localparam logic [7:0] CMD_COUNT   = 8'h63;
   localparam logic [7:0] CMD_SLEEP   = 8'h73;
   localparam logic [7:0] CMD_SETTIME = 8'h74;
   localparam logic [7:0] CMD_GETTIME = 8'h6E;
   localparam logic [7:0] CMD_NONE    = 8'hEE;

   // frame buffer and reply geometry
   localparam int unsigned RX_DEPTH    = 9;
   localparam int unsigned RX_IDX_W    = $clog2(RX_DEPTH);
   localparam int unsigned REPLY_BYTES = 4;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       asleep;
      logic       device_reset;
   } result_type;

endpackage

>>> hdl/ssce_in_stage.sv
// Input register for bus event transactions.
// Depends on ssce_pkg for the item type.
module ssce_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ssce_pkg::item_type req_item,
   input  logic               advance,
   output logic               item_valid,
   output ssce_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   ssce_pkg::item_type item_ff;

   // free when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hdl/ssce_engine.sv
// Command engine state: frame buffer, reply store, counters, clock and sleep.
// Produces the result for the held item; state moves on when advance is high.
// Depends on ssce_pkg.
module ssce_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ssce_pkg::item_type   item,
   output ssce_pkg::result_type result
);

   localparam int unsigned RXW = ssce_pkg::RX_IDX_W;

   logic [7:0]     rx_bytes_ff [ssce_pkg::RX_DEPTH];
   logic [7:0]     rx_bytes_in [ssce_pkg::RX_DEPTH];
   logic [RXW-1:0] rx_count_ff, rx_count_in;
   logic [7:0]     reply_bytes_ff [ssce_pkg::REPLY_BYTES];
   logic [7:0]     reply_bytes_in [ssce_pkg::REPLY_BYTES];
   logic           reply_valid_ff, reply_valid_in;
   logic [2:0]     reply_index_ff, reply_index_in;
   logic [31:0]    call_count_ff, call_count_in;
   logic [31:0]    half_count_ff, half_count_in;
   // running value of tick time plus offset, i.e. the reported clock
   logic [31:0]    clock_ff, clock_in;
   logic [31:0]    sleep_rem_ff, sleep_rem_in;
   logic           sleeping_ff, sleeping_in;

   logic [7:0]  cmd;
   logic [31:0] opnd_a, opnd_b;
   logic [31:0] call_inc;
   logic [31:0] clock_step, clock_sum;
   logic [31:0] reply_word;
   logic        known_cmd;
   logic        rearm;
   logic        pulse;
   logic [7:0]  rd_byte;

   assign cmd      = (rx_count_ff != '0) ? rx_bytes_ff[0] : ssce_pkg::CMD_NONE;
   assign opnd_a   = {rx_bytes_ff[4], rx_bytes_ff[3], rx_bytes_ff[2], rx_bytes_ff[1]};
   assign opnd_b   = {rx_bytes_ff[8], rx_bytes_ff[7], rx_bytes_ff[6], rx_bytes_ff[5]};
   assign call_inc = call_count_ff + 32'd1;

   // tick time is (half >> 1) + seconds; half wrap drops the halved term by 2^31-1
   always_comb begin
      if (item.operation == ssce_pkg::OP_HALF_TICK) begin
         if (half_count_ff == '1) begin
            clock_step = 32'h8000_0001;
         end else begin
            clock_step = {31'd0, half_count_ff[0]};
         end
      end else begin
         clock_step = 32'd1;
      end
   end
   assign clock_sum = clock_ff + clock_step;

   // reply value per command; set time replies with its operand
   always_comb begin
      known_cmd  = 1'b1;
      reply_word = opnd_a;
      case (cmd)
         ssce_pkg::CMD_ADD:     reply_word = opnd_a + opnd_b;
         ssce_pkg::CMD_SUB:     reply_word = opnd_a - opnd_b;
         ssce_pkg::CMD_COUNT:   reply_word = call_inc;
         ssce_pkg::CMD_SLEEP:   reply_word = opnd_a;
         ssce_pkg::CMD_SETTIME: reply_word = opnd_a;
         ssce_pkg::CMD_GETTIME: reply_word = clock_ff;
         default:               known_cmd  = 1'b0;
      endcase
   end

   // next state for the held transaction
   always_comb begin
      rx_bytes_in    = rx_bytes_ff;
      rx_count_in    = rx_count_ff;
      reply_bytes_in = reply_bytes_ff;
      reply_valid_in = reply_valid_ff;
      reply_index_in = reply_index_ff;
      call_count_in  = call_count_ff;
      half_count_in  = half_count_ff;
      clock_in       = clock_ff;
      sleep_rem_in   = sleep_rem_ff;
      sleeping_in    = sleeping_ff;
      rearm          = 1'b0;
      pulse          = 1'b0;
      rd_byte        = 8'h00;

      if (sleeping_ff) begin
         if (item.operation == ssce_pkg::OP_SEC_TICK) begin
            clock_in     = clock_sum;
            sleep_rem_in = sleep_rem_ff - 32'd1;
            if (sleep_rem_ff == 32'd1) begin
               sleeping_in = 1'b0;
               pulse       = 1'b1;
               rearm       = 1'b1;
            end
         end
      end else begin
         case (item.operation)
            ssce_pkg::OP_WRITE_BYTE: begin
               if (rx_count_ff < RXW'(ssce_pkg::RX_DEPTH)) begin
                  rx_bytes_in[rx_count_ff] = item.data_byte;
                  rx_count_in              = rx_count_ff + RXW'(1);
               end
            end
            ssce_pkg::OP_READ_BYTE: begin
               if (reply_valid_ff && !reply_index_ff[2]) begin
                  rd_byte        = reply_bytes_ff[reply_index_ff[1:0]];
                  reply_index_in = reply_index_ff + 3'd1;
               end
            end
            ssce_pkg::OP_WRITE_END: begin
               if (known_cmd) begin
                  call_count_in  = call_inc;
                  reply_valid_in = 1'b1;
                  for (int k = 0; k < ssce_pkg::REPLY_BYTES; k++) begin
                     reply_bytes_in[k] = reply_word[8*k +: 8];
                  end
                  if (cmd == ssce_pkg::CMD_SLEEP) begin
                     sleep_rem_in = opnd_a;
                  end
                  if (cmd == ssce_pkg::CMD_SETTIME) begin
                     clock_in = opnd_a;
                  end
               end
               rearm = 1'b1;
            end
            ssce_pkg::OP_READ_NACK: begin
               if (sleep_rem_ff != 32'd0) begin
                  sleeping_in = 1'b1;
               end else begin
                  rearm = 1'b1;
               end
            end
            ssce_pkg::OP_HALF_TICK: begin
               half_count_in = half_count_ff + 32'd1;
               clock_in      = clock_sum;
            end
            ssce_pkg::OP_SEC_TICK: begin
               clock_in = clock_sum;
            end
            default: begin
            end
         endcase
      end

      // start a fresh frame
      if (rearm) begin
         rx_count_in    = '0;
         reply_index_in = 3'd0;
         rx_bytes_in[0] = ssce_pkg::CMD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_bytes_ff[0] <= ssce_pkg::CMD_NONE;
         for (int i = 1; i < ssce_pkg::RX_DEPTH; i++) begin
            rx_bytes_ff[i] <= 8'h00;
         end
         for (int i = 0; i < ssce_pkg::REPLY_BYTES; i++) begin
            reply_bytes_ff[i] <= 8'h00;
         end
         rx_count_ff    <= '0;
         reply_valid_ff <= 1'b0;
         reply_index_ff <= 3'd0;
         call_count_ff  <= 32'd0;
         half_count_ff  <= 32'd0;
         clock_ff       <= 32'd0;
         sleep_rem_ff   <= 32'd0;
         sleeping_ff    <= 1'b0;
      end else if (advance) begin
         rx_bytes_ff    <= rx_bytes_in;
         reply_bytes_ff <= reply_bytes_in;
         rx_count_ff    <= rx_count_in;
         reply_valid_ff <= reply_valid_in;
         reply_index_ff <= reply_index_in;
         call_count_ff  <= call_count_in;
         half_count_ff  <= half_count_in;
         clock_ff       <= clock_in;
         sleep_rem_ff   <= sleep_rem_in;
         sleeping_ff    <= sleeping_in;
      end
   end

   assign result.read_byte    = rd_byte;
   assign result.asleep       = sleeping_in;
   assign result.device_reset = pulse;

   // checks
   a_pulse_wakes: assert property (@(posedge clock) disable iff (reset)
      advance && result.device_reset |-> !result.asleep && sleeping_ff)
      else $error("device reset without leaving sleep");

   a_pulse_at_one: assert property (@(posedge clock) disable iff (reset)
      advance && result.device_reset |-> sleep_rem_ff == 32'd1)
      else $error("device reset before countdown end");

   a_sleep_count: assert property (@(posedge clock) disable iff (reset)
      sleeping_ff |-> sleep_rem_ff != 32'd0)
      else $error("asleep with nothing left to count");

   a_sleep_ignores_bus: assert property (@(posedge clock) disable iff (reset)
      advance && sleeping_ff && item.operation != ssce_pkg::OP_SEC_TICK |=>
         $stable(clock_ff) && $stable(rx_count_ff) && $stable(half_count_ff))
      else $error("state changed by an event while asleep");

   a_frame_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= RXW'(ssce_pkg::RX_DEPTH))
      else $error("frame count beyond buffer depth");

endmodule

>>> hdl/ssce_out_stage.sv
// Result register for response transactions.
// Depends on ssce_pkg for the result type.
module ssce_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ssce_pkg::result_type result,
   output logic                 has_space,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ssce_pkg::result_type rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   ssce_pkg::result_type result_ff;

   // room when empty or when the held result is taken this cycle
   assign has_space = !valid_ff || rsp_ready;
   assign valid_in  = advance || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

>>> hdl/serial_slave_command_engine_core.sv
// Serial slave command engine: one bus event in, one result out.
// Path: the request is registered in the input stage, then its result in the result register.
// Throughput: one transaction per cycle; rsp_ready low with a full output holds both stages.
// Reset: synchronous, active high; frame buffer rearmed, reply, counters, clock, sleep cleared.
// Depends on ssce_pkg, ssce_in_stage, ssce_engine, ssce_out_stage.
module serial_slave_command_engine_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_asleep,
   output logic       rsp_device_reset
);

   ssce_pkg::item_type   req_item;
   ssce_pkg::item_type   item;
   ssce_pkg::result_type result;
   ssce_pkg::result_type rsp_result;
   logic                 item_valid;
   logic                 has_space;
   logic                 advance;

   assign req_item.operation = req_operation;
   assign req_item.data_byte = req_data_byte;

   // held item moves through the engine when the result register has room
   assign advance = item_valid && has_space;

   ssce_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ssce_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   ssce_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result     (result),
      .has_space  (has_space),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_read_byte    = rsp_result.read_byte;
   assign rsp_asleep       = rsp_result.asleep;
   assign rsp_device_reset = rsp_result.device_reset;

endmodule

>>> sim/tb_serial_slave_command_engine_core.sv
// Testbench for serial_slave_command_engine_core: bus events in, one result per transaction.
// A behavioural model of the engine predicts every result; directed and random traffic.
// Depends on ssce_pkg and the core RTL under hdl.
module tb_serial_slave_command_engine_core;

   // unused event codes, expected to be ignored
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int EVENT_TARGET = 450;
   localparam int SLEEP_SAFE   = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_operation = '0;
   logic [7:0] req_data_byte = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_byte;
   logic       rsp_asleep;
   logic       rsp_device_reset;

   serial_slave_command_engine_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_asleep       (rsp_asleep),
      .rsp_device_reset (rsp_device_reset)
   );

   always #10 clock = ~clock;

   // engine state as predicted
   logic [7:0]  eng_rx [ssce_pkg::RX_DEPTH];
   logic [3:0]  eng_rx_count;
   logic [7:0]  eng_reply [ssce_pkg::REPLY_BYTES];
   logic [2:0]  eng_reply_len;
   logic [2:0]  eng_reply_idx;
   logic [31:0] eng_calls;
   logic [31:0] eng_half_ticks;
   logic [31:0] eng_seconds;
   logic [31:0] eng_offset;
   logic [31:0] eng_sleep_left;
   logic        eng_sleeping;

   ssce_pkg::result_type results_due[$];
   int         mismatches = 0;
   int         cycle_count = 0;
   int         events_counted = 0;
   int         stall_left = 0;
   bit         quiet = 1'b0;

   function automatic logic [31:0] clock_now();
      return (eng_half_ticks >> 1) + eng_seconds;
   endfunction

   function automatic void store_reply(input logic [31:0] value);
      for (int i = 0; i < ssce_pkg::REPLY_BYTES; i++) eng_reply[i] = value[8*i +: 8];
      eng_reply_len = 3'd4;
   endfunction

   function automatic void rearm_frame();
      eng_rx_count  = '0;
      eng_reply_idx = '0;
      eng_rx[0]     = ssce_pkg::CMD_NONE;
   endfunction

   task automatic reset_engine_model();
      for (int i = 0; i < ssce_pkg::RX_DEPTH; i++) eng_rx[i] = '0;
      for (int i = 0; i < ssce_pkg::REPLY_BYTES; i++) eng_reply[i] = '0;
      eng_rx[0]      = ssce_pkg::CMD_NONE;
      eng_rx_count   = '0;
      eng_reply_len  = '0;
      eng_reply_idx  = '0;
      eng_calls      = '0;
      eng_half_ticks = '0;
      eng_seconds    = '0;
      eng_offset     = '0;
      eng_sleep_left = '0;
      eng_sleeping   = 1'b0;
   endtask

   // apply one accepted bus event to the model and queue its result
   task automatic predict_bus_event(input logic [2:0] op, input logic [7:0] data);
      ssce_pkg::result_type r;
      logic [7:0]  cmd;
      logic [31:0] a;
      logic [31:0] b;
      r = '0;
      if (eng_sleeping) begin
         if (op == ssce_pkg::OP_SEC_TICK) begin
            eng_seconds++;
            eng_sleep_left--;
            if (eng_sleep_left == 0) begin
               eng_sleeping   = 1'b0;
               r.device_reset = 1'b1;
               rearm_frame();
            end
         end
      end else begin
         case (op)
            ssce_pkg::OP_WRITE_BYTE: begin
               if (eng_rx_count < ssce_pkg::RX_DEPTH) begin
                  eng_rx[eng_rx_count] = data;
                  eng_rx_count++;
               end
            end
            ssce_pkg::OP_READ_BYTE: begin
               if (eng_reply_idx < eng_reply_len && eng_reply_idx < ssce_pkg::REPLY_BYTES) begin
                  r.read_byte = eng_reply[eng_reply_idx];
                  eng_reply_idx++;
               end
            end
            ssce_pkg::OP_WRITE_END: begin
               cmd = (eng_rx_count != 0) ? eng_rx[0] : ssce_pkg::CMD_NONE;
               a   = {eng_rx[4], eng_rx[3], eng_rx[2], eng_rx[1]};
               b   = {eng_rx[8], eng_rx[7], eng_rx[6], eng_rx[5]};
               case (cmd)
                  ssce_pkg::CMD_ADD: begin
                     store_reply(a + b);
                     eng_calls++;
                  end
                  ssce_pkg::CMD_SUB: begin
                     store_reply(a - b);
                     eng_calls++;
                  end
                  ssce_pkg::CMD_COUNT: begin
                     eng_calls++;
                     store_reply(eng_calls);
                  end
                  ssce_pkg::CMD_SLEEP: begin
                     eng_calls++;
                     eng_sleep_left = a;
                     store_reply(a);
                  end
                  ssce_pkg::CMD_SETTIME: begin
                     eng_calls++;
                     eng_offset = a - clock_now();
                     store_reply(clock_now() + eng_offset);
                  end
                  ssce_pkg::CMD_GETTIME: begin
                     eng_calls++;
                     store_reply(clock_now() + eng_offset);
                  end
                  default: ;
               endcase
               rearm_frame();
            end
            ssce_pkg::OP_READ_NACK: begin
               if (eng_sleep_left != 0) eng_sleeping = 1'b1;
               else rearm_frame();
            end
            ssce_pkg::OP_HALF_TICK: eng_half_ticks++;
            ssce_pkg::OP_SEC_TICK:  eng_seconds++;
            default: ;
         endcase
      end
      r.asleep = eng_sleeping;
      results_due.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      ssce_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report_mismatch("unexpected transaction", 32'd0, 32'(rsp_read_byte));
         end else begin
            want = results_due.pop_front();
            if (rsp_read_byte !== want.read_byte)
               report_mismatch("read_byte", 32'(want.read_byte), 32'(rsp_read_byte));
            if (rsp_asleep !== want.asleep)
               report_mismatch("asleep", 32'(want.asleep), 32'(rsp_asleep));
            if (rsp_device_reset !== want.device_reset)
               report_mismatch("device_reset", 32'(want.device_reset),
                               32'(rsp_device_reset));
         end
      end
   end

   // receiver back-pressure in short bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready  <= 1'b1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // one transaction on the request channel; valid is left high afterwards
   task automatic send_event(input logic [2:0] op, input logic [7:0] data);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (!eng_sleeping) events_counted++;
      predict_bus_event(op, data);
   endtask

   // command byte, operand bytes little-endian (A then B), extra bytes random, write end
   task automatic send_frame(input logic [7:0] cmd, input logic [31:0] a, input logic [31:0] b,
                             input int n_bytes);
      logic [63:0] operand_bytes;
      operand_bytes = {b, a};
      send_event(ssce_pkg::OP_WRITE_BYTE, cmd);
      for (int i = 0; i < n_bytes; i++)
         send_event(ssce_pkg::OP_WRITE_BYTE,
                    i < 8 ? operand_bytes[8*i +: 8] : 8'($urandom));
      send_event(ssce_pkg::OP_WRITE_END, 8'($urandom));
   endtask

   task automatic read_reply(input int n);
      repeat (n) send_event(ssce_pkg::OP_READ_BYTE, 8'($urandom));
   endtask

   // random event, avoiding a sleep too long to count down
   task automatic send_noise();
      logic [2:0] op;
      op = ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
      if (op == ssce_pkg::OP_READ_NACK && eng_sleep_left > SLEEP_SAFE)
         op = ssce_pkg::OP_READ_BYTE;
      send_event(op, 8'($urandom));
   endtask

   // NACK at end of read; sleeps are counted down with ignored traffic mixed in
   task automatic end_read();
      if (eng_sleep_left > SLEEP_SAFE) send_frame(ssce_pkg::CMD_SLEEP, '0, '0, 4);
      send_event(ssce_pkg::OP_READ_NACK, 8'($urandom));
      while (eng_sleeping) begin
         if ($urandom_range(0, 1) == 0) send_event(ssce_pkg::OP_SEC_TICK, 8'($urandom));
         else send_noise();
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // write end on an empty frame, read with no reply, spare codes
   task automatic test_empty_frame();
      send_event(ssce_pkg::OP_WRITE_END, 8'h00);
      send_event(ssce_pkg::OP_READ_BYTE, 8'hFF);
      send_event(OP_SPARE_6, 8'h5A);
      send_event(OP_SPARE_7, 8'hA5);
   endtask

   // add wraps, frame bytes beyond the ninth dropped, reads beyond the reply return zero
   task automatic test_add_wrap();
      send_frame(ssce_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0000_00FF, 10);
      read_reply(5);
      end_read();
   endtask

   // operands kept from the previous frame; unknown command keeps the old reply
   task automatic test_stale_operands();
      send_frame(ssce_pkg::CMD_SUB, '0, '0, 0);
      read_reply(2);
      send_frame(8'h00, '0, '0, 0);
      read_reply(1);
      send_event(ssce_pkg::OP_HALF_TICK, 8'h00);
      send_event(ssce_pkg::OP_SEC_TICK, 8'hFF);
      drain_results();
   endtask

   // sleep for two seconds with bus traffic ignored, then the reset pulse
   task automatic test_sleep_wake();
      send_frame(ssce_pkg::CMD_SLEEP, 32'd2, '0, 4);
      read_reply(1);
      send_event(ssce_pkg::OP_READ_NACK, 8'h00);
      send_event(ssce_pkg::OP_WRITE_BYTE, 8'hA5);
      send_event(ssce_pkg::OP_HALF_TICK, 8'h00);
      send_event(ssce_pkg::OP_SEC_TICK, 8'h00);
      send_event(ssce_pkg::OP_SEC_TICK, 8'h00);
   endtask

   // mostly whole command transactions with random content, some noise
   task automatic test_random_traffic();
      logic [7:0]  cmd;
      logic [31:0] a;
      logic [31:0] b;
      int          n_bytes;
      while (events_counted < EVENT_TARGET) begin
         if (events_counted > EVENT_TARGET - 60) quiet = 1'b1;
         if ($urandom_range(0, 99) < 75) begin
            case ($urandom_range(0, 6))
               0:       cmd = ssce_pkg::CMD_ADD;
               1:       cmd = ssce_pkg::CMD_SUB;
               2:       cmd = ssce_pkg::CMD_COUNT;
               3:       cmd = ssce_pkg::CMD_SLEEP;
               4:       cmd = ssce_pkg::CMD_SETTIME;
               5:       cmd = ssce_pkg::CMD_GETTIME;
               default: cmd = 8'($urandom);
            endcase
            a = pick_word();
            b = pick_word();
            if (cmd == ssce_pkg::CMD_SLEEP) begin
               case ($urandom_range(0, 7))
                  0:       a = 32'h8000_0000 | $urandom;
                  1:       a = '0;
                  default: a = $urandom_range(1, 4);
               endcase
            end
            n_bytes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : 8;
            repeat ($urandom_range(0, 2)) send_event(3'($urandom_range(4, 5)), 8'($urandom));
            send_frame(cmd, a, b, n_bytes);
            read_reply($urandom_range(0, 6));
            if ($urandom_range(0, 7) != 0) end_read();
         end else begin
            send_noise();
         end
         if ($urandom_range(0, 99) == 0) drain_results();
      end
   endtask

   initial begin
      reset_engine_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_frame();
      test_add_wrap();
      test_stale_operands();
      test_sleep_wake();
      test_random_traffic();
      drain_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

>>> serial_slave_command_engine_core.f
hdl/ssce_pkg.sv
hdl/ssce_in_stage.sv
hdl/ssce_engine.sv
hdl/ssce_out_stage.sv
hdl/serial_slave_command_engine_core.sv
sim/tb_serial_slave_command_engine_core.sv
